@@ rtl/core/lp2c_pkg.sv @@
`default_nettype none

package lp2c_pkg;

	localparam int MAX_BEAMS_DEF = 1024;
	localparam int CORDIC_STAGES_DEF = 16;

	// Rotator datapath width: range times gain stays below 2^49 in magnitude.
	localparam int DATA_W = 50;
	localparam int ANGLE_W = 32;
	localparam int RANGE_W = 16;
	localparam int INDEX_W = 10;
	localparam int COORD_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd3;

	localparam logic [ANGLE_W-1:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
		logic [RANGE_W-1:0] min_range;
		logic [RANGE_W-1:0] max_range;
	} lp2c_cfg_t;

	typedef struct packed {
		logic                      valid;
		logic [1:0]                quad;
		logic signed [DATA_W-1:0]  x;
		logic signed [DATA_W-1:0]  y;
		logic signed [ANGLE_W-1:0] z;
	} lp2c_cell_t;

	// Inverse CORDIC gain in Q32, evaluated at elaboration with integer steps only.
	function automatic logic [31:0] lp2c_gain(input int stages);
		logic [63:0] p;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bitv;
		logic [64:0] rem;
		logic [63:0] quo;
		p = 64'd1 << 60;
		for (int i = 0; i < 32; i++) begin
			if (i < stages) begin
				p = p + (p >> (2 * i));
			end
		end
		n = p << 2;
		res = '0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		rem = '0;
		quo = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], (k == 63)};
			if (rem >= {1'b0, res}) begin
				rem = rem - {1'b0, res};
				quo[k] = 1'b1;
			end
		end
		return quo[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lp2c_front.sv @@
`default_nettype none

module lp2c_front #(
	parameter int MAX_BEAMS = lp2c_pkg::MAX_BEAMS_DEF,
	parameter int CORDIC_STAGES = lp2c_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [lp2c_pkg::INDEX_W-1:0]      beam_index,
	input  wire logic [lp2c_pkg::RANGE_W-1:0]      range_mm,
	input  wire lp2c_pkg::lp2c_cfg_t               cfg,
	output lp2c_pkg::lp2c_cell_t                   cell_out
);
	import lp2c_pkg::*;

	localparam logic [31:0] GAIN = lp2c_gain(CORDIC_STAGES);

	logic                keep;
	logic                valid_s1;
	logic [ANGLE_W-1:0]  prod_s1;
	logic [RANGE_W-1:0]  range_s1;
	logic [ANGLE_W-1:0]  angle;
	logic [1:0]          quad;
	logic [ANGLE_W-1:0]  resid;
	logic [47:0]         scaled;

	assign keep = start && (32'(beam_index) < 32'(MAX_BEAMS))
		&& (range_mm >= cfg.min_range) && (range_mm <= cfg.max_range);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cell_out <= '0;
		end else begin
			valid_s1 <= keep;
			cell_out.valid <= valid_s1;
			cell_out.quad <= quad;
			cell_out.x <= $signed({2'b00, scaled});
			cell_out.y <= '0;
			cell_out.z <= $signed(resid);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {22'b0, beam_index} * cfg.angle_step;
		range_s1 <= range_mm;
	end

	assign angle = cfg.start_angle + prod_s1;
	assign quad = 2'((angle + 32'h2000_0000) >> 30);
	assign resid = angle - {quad, 30'b0};
	assign scaled = {32'b0, range_s1} * {16'b0, GAIN};

endmodule

`default_nettype wire

@@ rtl/core/lp2c_cell.sv @@
`default_nettype none

module lp2c_cell #(
	parameter int STAGE = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lp2c_pkg::lp2c_cell_t  cell_in,
	output lp2c_pkg::lp2c_cell_t       cell_out
);
	import lp2c_pkg::*;

	logic signed [DATA_W-1:0]  xs;
	logic signed [DATA_W-1:0]  ys;
	logic signed [ANGLE_W-1:0] step_angle;

	assign xs = cell_in.x >>> STAGE;
	assign ys = cell_in.y >>> STAGE;
	assign step_angle = $signed(ATAN_TAB[STAGE]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out.valid <= cell_in.valid;
			cell_out.quad <= cell_in.quad;
			if (!cell_in.z[ANGLE_W-1]) begin
				cell_out.x <= cell_in.x - ys;
				cell_out.y <= cell_in.y + xs;
				cell_out.z <= cell_in.z - step_angle;
			end else begin
				cell_out.x <= cell_in.x + ys;
				cell_out.y <= cell_in.y - xs;
				cell_out.z <= cell_in.z + step_angle;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lp2c_back.sv @@
`default_nettype none

module lp2c_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lp2c_pkg::lp2c_cell_t                cell_in,
	output logic                                     done,
	output logic signed [lp2c_pkg::COORD_W-1:0]      x_mm,
	output logic signed [lp2c_pkg::COORD_W-1:0]      y_mm
);
	import lp2c_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic signed [DATA_W-1:0] ox;
	logic signed [DATA_W-1:0] oy;

	function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] t;
		logic signed [DATA_W-33:0] r;
		t = v + (DATA_W'(1) << 31);
		r = t[DATA_W-1:32];
		if (r > (DATA_W-32)'(65535)) begin
			return COORD_W'(65535);
		end else if (r < -(DATA_W-32)'(65535)) begin
			return -COORD_W'(65535);
		end
		return r[COORD_W-1:0];
	endfunction

	always_comb begin
		case (cell_in.quad)
			QUAD_0: begin
				ox = cell_in.x;
				oy = cell_in.y;
			end
			QUAD_1: begin
				ox = -cell_in.y;
				oy = cell_in.x;
			end
			QUAD_2: begin
				ox = -cell_in.x;
				oy = -cell_in.y;
			end
			QUAD_3: begin
				ox = cell_in.y;
				oy = -cell_in.x;
			end
			default: begin
				ox = cell_in.x;
				oy = cell_in.y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_mm <= round_sat(ox);
		y_mm <= round_sat(oy);
	end

endmodule

`default_nettype wire

@@ rtl/core/lidar_polar_to_cartesian.sv @@
// A start passes the front registers, each CORDIC cell register and the done register in turn.
// Throughput: one beam per cycle; busy stays low, set by the rotator chain of one cell per stage.
// Beams outside the range window or beyond MAX_BEAMS produce no done strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears valid and cell state, not x_mm/y_mm, and restores the configuration defaults.
`default_nettype none

module lidar_polar_to_cartesian #(
	parameter int MAX_BEAMS = lp2c_pkg::MAX_BEAMS_DEF,
	parameter int CORDIC_STAGES = lp2c_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [lp2c_pkg::INDEX_W-1:0]          beam_index,
	input  wire logic [lp2c_pkg::RANGE_W-1:0]          range_mm,
	output logic                                       done,
	output logic signed [lp2c_pkg::COORD_W-1:0]        x_mm,
	output logic signed [lp2c_pkg::COORD_W-1:0]        y_mm,
	input  wire logic                                  cfg_we,
	input  wire logic [lp2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [lp2c_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import lp2c_pkg::*;

	localparam int LAT = CORDIC_STAGES + 3;

	lp2c_cfg_t  cfg_q;
	lp2c_cell_t chain [CORDIC_STAGES+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle <= '0;
			cfg_q.angle_step <= '0;
			cfg_q.min_range <= '0;
			cfg_q.max_range <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ANGLE: cfg_q.start_angle <= cfg_wdata;
				REG_ANGLE_STEP: cfg_q.angle_step <= cfg_wdata;
				REG_MIN_RANGE: cfg_q.min_range <= cfg_wdata[RANGE_W-1:0];
				REG_MAX_RANGE: cfg_q.max_range <= cfg_wdata[RANGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lp2c_front #(
		.MAX_BEAMS(MAX_BEAMS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start && !busy),
		.beam_index(beam_index),
		.range_mm(range_mm),
		.cfg(cfg_q),
		.cell_out(chain[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		lp2c_cell #(
			.STAGE(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_in(chain[i]),
			.cell_out(chain[i+1])
		);
	end

	lp2c_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cell_in(chain[CORDIC_STAGES]),
		.done(done),
		.x_mm(x_mm),
		.y_mm(y_mm)
	);

`ifndef SYNTHESIS
	// Every result traces back to an accepted transaction.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without a matching start");

	// A beam index beyond the scan size never yields a result.
	a_index_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (32'(beam_index) >= 32'(MAX_BEAMS))) |-> ##(LAT) !done)
		else $error("out-of-scan beam produced a result");

	// Saturation keeps x inside the symmetric output range.
	a_x_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (x_mm != -COORD_W'(65536)))
		else $error("x_mm outside saturation range");

	// Saturation keeps y inside the symmetric output range.
	a_y_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (y_mm != -COORD_W'(65536)))
		else $error("y_mm outside saturation range");
`endif

endmodule

`default_nettype wire
